[rtl/core/p3fc_pkg.sv]
// Shared types, constants and helpers of the POP3 flow classifier.
`timescale 1ns / 1ps

package p3fc_pkg;

	localparam int CMD_COUNT = 11;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_INDEX_W = 1;

	// register indexes on the config port
	localparam logic [CFG_INDEX_W-1:0] CFG_TLS_SWITCH_EN = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXCLUDE_AFTER = 1'd1;

	localparam logic [7:0] EXCLUDE_AFTER_RST = 8'd12;
	localparam logic [15:0] CRLF_WORD = 16'h0d0a;
	localparam logic [8:0] DETECT_THRESHOLD = 9'd3;
	localparam logic [7:0] RESP_MAX = 8'hff;

	// command bit positions in the seen mask
	localparam int CMD_USER = 2;
	localparam int CMD_PASS = 3;
	localparam int CMD_STLS = 10;

	typedef enum logic [1:0] {
		VERDICT_NONE     = 2'd0,
		VERDICT_POP      = 2'd1,
		VERDICT_POPS     = 2'd2,
		VERDICT_EXCLUDED = 2'd3
	} verdict_t;

	typedef logic [CMD_COUNT-1:0] cmd_mask_t;

	// command words, byte 0 in bits 31..24
	typedef logic [31:0] cmd_word_t;
	localparam cmd_word_t CMD_WORDS [CMD_COUNT] = '{
		"AUTH", "APOP", "USER", "PASS", "CAPA", "LIST",
		"STAT", "UIDL", "RETR", "DELE", "STLS"
	};

	// one packet summary as it enters the block
	typedef struct packed {
		logic        new_flow;
		logic [15:0] payload_length;
		logic [31:0] head_bytes;
		logic [15:0] tail_bytes;
		logic        argument_present;
		logic [7:0]  packet_index;
	} item_t;

	// what the decoder found in the leading bytes
	typedef struct packed {
		logic      is_ok;
		logic      is_err;
		cmd_mask_t cmd;
		logic      crlf;
	} token_t;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic [7:0] response_total;
		cmd_mask_t  seen_commands;
		logic       cleartext_credentials;
		logic       extra_inspection;
		logic       switch_to_tls;
		verdict_t   verdict;
	} result_t;

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		if (c >= "a" && c <= "z") begin
			return c - 8'd32;
		end
		return c;
	endfunction

	function automatic logic [3:0] count_cmds(input cmd_mask_t m);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < CMD_COUNT; i++) begin
			n = n + {3'd0, m[i]};
		end
		return n;
	endfunction

endpackage

[rtl/core/p3fc_decode.sv]
// Token decoder: case-folded match of the leading bytes, CRLF check.
`timescale 1ns / 1ps

module p3fc_decode (
	input  p3fc_pkg::item_t  item,
	output p3fc_pkg::token_t tok
);
	import p3fc_pkg::*;

	logic [31:0] folded;
	logic        len_gt2;
	logic        len_gt3;
	logic        len_gt4;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			folded[8*i +: 8] = fold_upper(item.head_bytes[8*i +: 8]);
		end
	end

	assign len_gt2 = item.payload_length > 16'd2;
	assign len_gt3 = item.payload_length > 16'd3;
	assign len_gt4 = item.payload_length > 16'd4;

	always_comb begin
		tok.crlf   = len_gt2 && (item.tail_bytes == CRLF_WORD);
		tok.is_ok  = len_gt3 && (folded[31:8] == "+OK");
		tok.is_err = len_gt4 && (folded == "-ERR");
		// command words are distinct, so at most one bit is set
		for (int k = 0; k < CMD_COUNT; k++) begin
			tok.cmd[k] = len_gt4 && (folded == CMD_WORDS[k]);
		end
	end

endmodule

[rtl/core/p3fc_flow.sv]
// Per-flow state and verdict logic; state updates when a word leaves stage 1.
`timescale 1ns / 1ps

module p3fc_flow (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  p3fc_pkg::item_t   item,
	input  p3fc_pkg::token_t  tok,
	input  logic              tls_switch_enable,
	input  logic [7:0]        exclude_after_packets,
	output p3fc_pkg::result_t res
);
	import p3fc_pkg::*;

	cmd_mask_t  mask_q;
	logic [7:0] resp_q;
	logic       stls_q;
	logic       pw_q;

	cmd_mask_t  mask_cur, mask_n;
	logic [7:0] resp_cur, resp_n;
	logic       stls_cur, stls_n;
	logic       pw_cur, pw_n;
	logic       matched;
	logic       finished;
	logic       keep;
	logic [8:0] score;

	// new_flow wipes state before this packet is looked at
	always_comb begin
		mask_cur = item.new_flow ? '0 : mask_q;
		resp_cur = item.new_flow ? '0 : resp_q;
		stls_cur = item.new_flow ? 1'b0 : stls_q;
		pw_cur   = item.new_flow ? 1'b0 : pw_q;
	end

	always_comb begin
		mask_n = mask_cur | tok.cmd;
		resp_n = resp_cur;
		if ((tok.is_ok || tok.is_err) && resp_cur != RESP_MAX) begin
			resp_n = resp_cur + 8'd1;
		end
		stls_n = stls_cur;
		if (tok.is_err) begin
			stls_n = 1'b0;
		end else if (tok.cmd[CMD_STLS]) begin
			stls_n = 1'b1;
		end
		pw_n = tok.cmd[CMD_PASS] ? item.argument_present : pw_cur;
	end

	assign matched  = tok.is_ok || tok.is_err || (|tok.cmd);
	assign finished = tok.is_ok && stls_cur && tls_switch_enable;
	assign score    = {5'd0, count_cmds(mask_n)} + {1'b0, resp_n};
	assign keep     = (tok.crlf || mask_cur != '0 || resp_cur != '0) &&
		(item.packet_index < exclude_after_packets);

	always_comb begin
		res                       = '0;
		res.verdict               = VERDICT_NONE;
		res.switch_to_tls         = finished;
		res.cleartext_credentials = tok.cmd[CMD_USER] || tok.cmd[CMD_PASS];
		res.seen_commands         = mask_n;
		res.response_total        = resp_n;
		if (tok.is_ok && stls_cur) begin
			res.verdict = VERDICT_POPS;
		end
		if (matched) begin
			if (!finished && tok.crlf && score >= DETECT_THRESHOLD && resp_n != '0 &&
				(pw_n || {1'b0, resp_n} >= DETECT_THRESHOLD)) begin
				res.verdict          = VERDICT_POP;
				res.extra_inspection = !pw_n;
			end
		end else if (!keep) begin
			res.verdict = VERDICT_EXCLUDED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			resp_q <= '0;
			stls_q <= 1'b0;
			pw_q   <= 1'b0;
		end else if (upd) begin
			mask_q <= mask_n;
			resp_q <= resp_n;
			stls_q <= stls_n;
			pw_q   <= pw_n;
		end
	end

	// within a flow the response count never goes backward
	a_resp_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && !item.new_flow) |-> (resp_n >= resp_q))
		else $error("response count decreased within a flow");

	// within a flow the command mask only gains bits
	a_mask_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && !item.new_flow) |-> ((mask_n & mask_q) == mask_q))
		else $error("command mask lost a bit within a flow");

	a_switch_pops: assert property (@(posedge clk) disable iff (!arst_n)
		res.switch_to_tls |-> (res.verdict == VERDICT_POPS))
		else $error("TLS switch without POPS verdict");

	a_extra_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res.extra_inspection |-> (res.verdict == VERDICT_POP))
		else $error("extra inspection without POP verdict");

	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> ($stable(mask_q) && $stable(resp_q)))
		else $error("flow state changed with no word retired");

endmodule

[rtl/core/pop3_flow_classifier.sv]
// Top level of the POP3 flow classifier: stream ports, config, pipeline registers.
`timescale 1ns / 1ps

// POP3 flow classifier. Takes one packet summary word per clock on the
// s_ stream while s_tready is high and returns one result word per packet
// on the m_ stream, in order, through the input register, then the result
// register; with m_tready held high the block sustains one word per cycle.
// The rate is set by the flow-state read-modify-write in p3fc_flow, which
// is done in the cycle a word moves from the input register to the result
// register. While a result waits with m_tready low, the input register
// still takes one more word; after that intake stalls until the result is
// taken.
// Config writes (cfg_we/cfg_index/cfg_wdata) take effect on the next edge
// and must be made only while no word is in flight.
module pop3_flow_classifier (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config write port
	input  logic                                  cfg_we,
	input  logic [p3fc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [p3fc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	// packet summary stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [15:0] payload_length, [47:16] head_bytes, [63:48] tail_bytes,
	// [64] argument_present, [72:65] packet_index, [79:73] zero
	input  logic [p3fc_pkg::IN_DATA_W-1:0]        s_tdata,
	// [0] new_flow
	input  logic                                  s_tuser,
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [1:0] verdict, [2] switch_to_tls, [3] extra_inspection,
	// [4] cleartext_credentials, [15:5] seen_commands, [23:16] response_total
	output logic [p3fc_pkg::OUT_DATA_W-1:0]       m_tdata
);
	import p3fc_pkg::*;

	// config registers
	logic       tls_en_q;
	logic [7:0] excl_after_q;

	// stage 1: captured packet summary
	logic    valid_s1;
	item_t   item_s1;
	// stage 2: result word held for the consumer
	logic    valid_s2;
	result_t res_s2;

	token_t  tok;
	result_t res;
	logic    adv;     // stage 1 word retires into stage 2 this cycle
	logic    in_acc;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tls_en_q     <= 1'b0;
			excl_after_q <= EXCLUDE_AFTER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TLS_SWITCH_EN: tls_en_q     <= cfg_wdata[0];
				CFG_EXCLUDE_AFTER: excl_after_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.new_flow         <= s_tuser;
			item_s1.payload_length   <= s_tdata[15:0];
			item_s1.head_bytes       <= s_tdata[47:16];
			item_s1.tail_bytes       <= s_tdata[63:48];
			item_s1.argument_present <= s_tdata[64];
			item_s1.packet_index     <= s_tdata[72:65];
		end
	end

	p3fc_decode u_decode (
		.item (item_s1),
		.tok  (tok)
	);

	p3fc_flow u_flow (
		.clk                   (clk),
		.arst_n                (arst_n),
		.upd                   (adv),
		.item                  (item_s1),
		.tok                   (tok),
		.tls_switch_enable     (tls_en_q),
		.exclude_after_packets (excl_after_q),
		.res                   (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	// a stalled result must not change under the consumer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(valid_s2 && !m_tready) |-> (valid_s2 && $stable(res_s2)))
		else $error("result word changed while stalled");

	// a captured word cannot be overwritten before it retires
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> !s_tready)
		else $error("input register overrun");

	// a retiring word always lands in the result register
	a_retire: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("retired word lost");

endmodule
